// File: rtl/uks_pkg.sv
// Shared types for the unique-key stack: command and status codes.
// No dependencies; imported by the stack top level and its checker.
package uks_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_LEN  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

// File: rtl/uks_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module uks_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/unique_key_stack.sv
// Unique-key stack top level: command sequencer around one key/data RAM.
// Depends on uks_pkg and uks_ram.
//
// Usage:
//   Slave channel takes one command word: tuser carries the command (push,
//   pop, peek, length query), tdata the key and payload of a push.
//   Master channel returns one result word per command: tuser carries the
//   status, tdata the returned key and payload, entry count and empty flag.
//   A push scans every stored key, one RAM read per cycle, before it writes,
//   and stops early when a duplicate is found. Pop and peek pass through
//   S_TOP and S_TOPD to read the top entry; the length query and pop or peek
//   on an empty stack go straight to S_RESP. One command is in work at a
//   time, and the next is taken in the cycle after the result is registered.
//   The next command is taken while the result word in the output register
//   still waits for the receiver.
//   When the receiver stalls, the result word holds and the sequencer waits
//   with the following result until the output register frees.
//   Reset (synchronous, active low) empties the stack and drops any pending
//   result; the RAM contents are not cleared, only entries below the fill
//   level are ever used.
module unique_key_stack
    import uks_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 16,
    parameter int DATA_BITS = 32,
    localparam int CNT_BITS = $clog2(DEPTH + 1),
    localparam int IN_W     = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((KEY_BITS + DATA_BITS + CNT_BITS + 1 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // in_key, in_data, zero pad
    input  logic [1:0]       s_axis_tuser,  // command
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // out_key, out_data, entry_count, is_empty, pad
    output logic [1:0]       m_axis_tuser   // status
);

    localparam int AW    = $clog2(DEPTH);
    localparam int RAM_W = KEY_BITS + DATA_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TOP,
        S_TOPD,
        S_RESP
    } t_state;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [DATA_BITS-1:0]  r_data;
    logic [CNT_BITS-1:0]   r_fill;
    logic [CNT_BITS-1:0]   r_idx;
    logic                  r_pend;
    t_status               r_res_status;
    logic [KEY_BITS-1:0]   r_res_key;
    logic [DATA_BITS-1:0]  r_res_data;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [KEY_BITS-1:0]   r_out_key;
    logic [DATA_BITS-1:0]  r_out_data;
    logic [CNT_BITS-1:0]   r_out_cnt;
    logic                  r_out_empty;

    t_cmd                  in_cmd;
    logic [KEY_BITS-1:0]   in_key;
    logic [DATA_BITS-1:0]  in_data;
    logic [RAM_W-1:0]      rd_word;
    logic [KEY_BITS-1:0]   rd_key;
    logic [DATA_BITS-1:0]  rd_data;
    logic                  scan_hit;
    logic                  scan_done;
    logic                  is_full;
    logic                  wr_en;

    assign in_cmd  = t_cmd'(s_axis_tuser);
    assign in_key  = s_axis_tdata[KEY_BITS-1:0];
    assign in_data = s_axis_tdata[KEY_BITS +: DATA_BITS];

    assign rd_key  = rd_word[KEY_BITS-1:0];
    assign rd_data = rd_word[KEY_BITS +: DATA_BITS];

    assign is_full   = (r_fill == CNT_BITS'(DEPTH));
    assign scan_hit  = (r_state == S_SCAN) && r_pend && (rd_key == r_key);
    assign scan_done = (r_state == S_SCAN) && !r_pend && (r_idx == r_fill);
    assign wr_en     = scan_done && !is_full;

    uks_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data ({r_data, r_key}),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd      <= in_cmd;
                        r_key      <= in_key;
                        r_data     <= in_data;
                        r_res_key  <= '0;
                        r_res_data <= '0;
                        case (in_cmd)
                            CMD_PUSH: begin
                                r_idx   <= '0;
                                r_pend  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            CMD_POP, CMD_PEEK: begin
                                if (r_fill == '0) begin
                                    r_res_status <= ST_EMPTY;
                                    r_state      <= S_RESP;
                                end else begin
                                    r_idx   <= r_fill - 1'b1;
                                    r_state <= S_TOP;
                                end
                            end
                            default: begin
                                r_res_status <= ST_OK;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_res_status <= ST_DUP;
                        r_state      <= S_RESP;
                    end else if (scan_done) begin
                        if (is_full) begin
                            r_res_status <= ST_FULL;
                        end else begin
                            r_res_status <= ST_OK;
                            r_fill       <= r_fill + 1'b1;
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_pend <= (r_idx < r_fill);
                        if (r_idx < r_fill) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_TOP: begin
                    r_state <= S_TOPD;
                end
                S_TOPD: begin
                    r_res_status <= ST_OK;
                    r_res_key    <= rd_key;
                    r_res_data   <= rd_data;
                    if (r_cmd == CMD_POP) begin
                        r_fill <= r_fill - 1'b1;
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_key    <= r_res_key;
                        r_out_data   <= r_res_data;
                        r_out_cnt    <= r_fill;
                        r_out_empty  <= (r_fill == '0);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_W'({r_out_empty, r_out_cnt, r_out_data, r_out_key});

endmodule

// File: rtl/uks_checker.sv
// Port-level checker for the unique-key stack, bound to the top level.
// Depends on uks_pkg and unique_key_stack.
module uks_checker
    import uks_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int KEY_BITS  = 16,
    parameter int DATA_BITS = 32,
    localparam int CNT_BITS = $clog2(DEPTH + 1),
    localparam int IN_W     = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((KEY_BITS + DATA_BITS + CNT_BITS + 1 + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic [1:0]       s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [1:0]       m_axis_tuser
);

    localparam int CNT_LO = KEY_BITS + DATA_BITS;
    localparam int EMP_BIT = CNT_LO + CNT_BITS;

    logic [CNT_BITS-1:0] out_cnt;
    logic                out_empty;
    logic                in_word;

    assign out_cnt   = m_axis_tdata[CNT_LO +: CNT_BITS];
    assign out_empty = m_axis_tdata[EMP_BIT];
    assign in_word   = s_axis_tvalid && s_axis_tready && (s_axis_tuser != '1);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command word taken while one is in work");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_empty == (out_cnt == '0)) && (out_cnt <= CNT_BITS'(DEPTH)))
        else $error("empty flag or entry count inconsistent");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
            out_empty && (m_axis_tdata[CNT_LO-1:0] == '0))
        else $error("empty status with data or entries");

    logic unused_in;
    assign unused_in = in_word ^ (^s_axis_tdata);

endmodule

bind unique_key_stack uks_checker #(
    .DEPTH     (DEPTH),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
) u_uks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb.sv
// Testbench for the unique-key stack: directed and random push, pop, peek and
// length-query words, checked against a local model of the stack.
// Depends on uks_pkg and the unique_key_stack top level.
module tb;
    import uks_pkg::*;

    localparam int DEPTH         = 16;
    localparam int IN_W          = 48;
    localparam int OUT_W         = 56;
    localparam int MAX_GAP       = 18;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS  = 1775;
    localparam int SEGMENT_WORDS = 30;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN} t_mix;

    typedef struct packed {
        t_status     status;
        logic [15:0] key;
        logic [31:0] data;
        logic [4:0]  count;
        logic        empty;
    } t_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;  // in_key, in_data
    logic [1:0]       s_axis_tuser = CMD_LEN;  // command
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;  // out_key, out_data, entry_count, is_empty, pad
    logic [1:0]       m_axis_tuser;  // status

    logic [15:0] stack_keys [DEPTH];
    logic [31:0] stack_data [DEPTH];
    int unsigned stack_level = 0;
    t_result     pending_results[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          words_sent = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    bit          quiet = 1'b0;

    unique_key_stack uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_result apply_command(t_cmd cmd, logic [15:0] key, logic [31:0] data);
        t_result r = '0;
        bit      dup = 1'b0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                for (int i = 0; i < stack_level; i++)
                    if (stack_keys[i] == key) dup = 1'b1;
                if (dup) begin
                    r.status = ST_DUP;
                end else if (stack_level >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_keys[stack_level] = key;
                    stack_data[stack_level] = data;
                    stack_level++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (stack_level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key  = stack_keys[stack_level - 1];
                    r.data = stack_data[stack_level - 1];
                    if (cmd == CMD_POP) stack_level--;
                end
            end
            default: ;
        endcase
        r.count = stack_level[4:0];
        r.empty = (stack_level == 0);
        return r;
    endfunction

    task automatic send_word(input t_cmd cmd, input logic [15:0] key, input logic [31:0] data);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {data, key};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_command(cmd, key, data));
        words_sent++;
        @(negedge i_clk);
    endtask

    // hold off until every outstanding result has been returned
    task automatic drain_results;
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_empty_stack;
        send_word(CMD_POP, 16'($urandom), $urandom);
        send_word(CMD_PEEK, 16'($urandom), $urandom);
        send_word(CMD_LEN, 16'($urandom), $urandom);
    endtask

    task automatic test_extremes;
        send_word(CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(CMD_PUSH, 16'h0000, 32'h0000_0000);
        send_word(CMD_PUSH, 16'h0000, 32'hA5A5_5A5A);
        send_word(CMD_PEEK, 16'h0000, 32'h0000_0000);
        send_word(CMD_LEN, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_to_full;
        for (int i = 0; stack_level < DEPTH; i++)
            send_word(CMD_PUSH, 16'(16'h1000 + i), $urandom);
        send_word(CMD_PUSH, 16'h7777, $urandom);
        send_word(CMD_PUSH, 16'hFFFF, $urandom);
        send_word(CMD_POP, 16'($urandom), $urandom);
    endtask

    function automatic t_cmd pick_command(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   return r < 65 ? CMD_PUSH : r < 80 ? CMD_POP : r < 93 ? CMD_PEEK : CMD_LEN;
            MIX_SHRINK: return r < 20 ? CMD_PUSH : r < 75 ? CMD_POP : r < 92 ? CMD_PEEK : CMD_LEN;
            default:    return r < 45 ? CMD_PUSH : r < 75 ? CMD_POP : r < 90 ? CMD_PEEK : CMD_LEN;
        endcase
    endfunction

    // keys mostly repeat held or small values so duplicates are common
    function automatic logic [15:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3 && stack_level > 0) return stack_keys[$urandom_range(0, stack_level - 1)];
        if (r < 6) return 16'($urandom_range(0, 31));
        return 16'($urandom);
    endfunction

    task automatic test_random;
        t_mix mix;
        mix = MIX_GROW;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % SEGMENT_WORDS == 0) begin
                mix   = t_mix'($urandom_range(0, 2));
                quiet = ($urandom_range(0, 4) == 0);
            end
            if (n == RANDOM_WORDS / 2) drain_results();
            send_word(pick_command(mix), pick_key(), $urandom);
        end
        quiet = 1'b0;
    endtask

    initial begin
        int stall;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    function automatic void compare_field(string field, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.status = t_status'(m_axis_tuser);
            seen.key    = m_axis_tdata[15:0];
            seen.data   = m_axis_tdata[47:16];
            seen.count  = m_axis_tdata[52:48];
            seen.empty  = m_axis_tdata[53];
            status_seen[seen.status]++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %0h", $time, seen);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", want.status, seen.status);
                compare_field("out_key", want.key, seen.key);
                compare_field("out_data", want.data, seen.data);
                compare_field("entry_count", want.count, seen.count);
                compare_field("is_empty", want.empty, seen.empty);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else if (i_rst_n)
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_empty_stack();
        test_extremes();
        test_fill_to_full();
        drain_results();
        test_random();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d commands: %0d ok, %0d duplicate, %0d empty, %0d full results",
                 words_sent, status_seen[ST_OK], status_seen[ST_DUP],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results outstanding", error_count,
                     pending_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
